>>> hw/rtl/pic_pkg.sv
// shared types, constants and helpers for the panel input conditioner
`timescale 1ns / 1ps
`default_nettype none

package pic_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_HOLD_TIME        = 3'd0;
    localparam logic [2:0] REG_LINK_TIMEOUT     = 3'd1;
    localparam logic [2:0] REG_STATUS_PERIOD    = 3'd2;
    localparam logic [2:0] REG_JOURNAL_PERIOD   = 3'd3;
    localparam logic [2:0] REG_BUTTON_PERIOD    = 3'd4;
    localparam logic [2:0] REG_INITIAL_SETPOINT = 3'd5;
    localparam logic [2:0] REG_INITIAL_POWER    = 3'd6;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // register reset values
    localparam logic [15:0] HOLD_TIME_RST        = 16'd800;
    localparam logic [15:0] LINK_TIMEOUT_RST     = 16'd2000;
    localparam logic [15:0] STATUS_PERIOD_RST    = 16'd100;
    localparam logic [15:0] JOURNAL_PERIOD_RST   = 16'd10000;
    localparam logic [7:0]  BUTTON_PERIOD_RST    = 8'd10;
    localparam logic [5:0]  INITIAL_SETPOINT_RST = 6'd30;
    localparam logic [6:0]  INITIAL_POWER_RST    = 7'd60;

    // operating modes
    localparam logic [1:0] MODE_AUTO   = 2'd0;
    localparam logic [1:0] MODE_MANUAL = 2'd1;

    // beep bits
    localparam int BEEP_SHORT = 0;
    localparam int BEEP_LONG  = 1;

    // adjustment limits, widened to hold the sums
    localparam logic [6:0] SETPOINT_MIN = 7'd10;
    localparam logic [6:0] SETPOINT_MAX = 7'd60;
    localparam logic [7:0] POWER_MIN    = 8'd30;
    localparam logic [7:0] POWER_MAX    = 8'd100;
    localparam logic [7:0] POWER_STEP   = 8'd5;

    localparam logic [1:0] ENC_REST    = 2'b11;
    localparam logic [2:0] BTN_RELEASE = 3'b111;
    localparam logic [2:0] BTN_DOWN    = 3'b000;

    typedef struct packed {
        logic signed [1:0] enc_to_panel;
        logic              press_to_panel;
        logic              hold_to_panel;
        logic              start_stop;
        logic [1:0]        beep;
        logic [5:0]        setpoint;
        logic [6:0]        power_percent;
        logic              save_request;
        logic              panel_ok;
        logic              link_came_up;
        logic              status_due;
        logic              send_journal;
    } res_t;

    // quadrature transition table: {previous ab, current ab} -> direction
    function automatic logic signed [1:0] enc_dir(input logic [3:0] idx);
        logic signed [1:0] d;
        begin
            case (idx)
                4'd13, 4'd4, 4'd2, 4'd11: d = 2'sd1;
                4'd14, 4'd8, 4'd1, 4'd7:  d = -2'sd1;
                default:                  d = 2'sd0;
            endcase
            return d;
        end
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/pic_out_buf.sv
// two-entry result buffer: output register plus skid register
`timescale 1ns / 1ps
`default_nettype none

module pic_out_buf (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire pic_pkg::res_t push_data,
    output logic               ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    output pic_pkg::res_t      out_data
);
    import pic_pkg::*;

    res_t out_reg, out_next;
    res_t skid_reg, skid_next;
    logic out_valid_reg, out_valid_next;
    logic skid_valid_reg, skid_valid_next;
    logic pop;

    assign pop       = out_valid_reg && out_ready;
    assign ready     = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_next       = push_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

`ifndef ASSERT_OFF
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output register");

    a_skid_kept: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && !out_ready |=> skid_valid_reg && $stable(skid_reg))
        else $error("skid entry lost while output stalled");

    a_skid_moves: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && out_ready |=> !skid_valid_reg && out_valid_reg
            && out_reg == $past(skid_reg))
        else $error("skid entry not moved to output on transfer");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        push && ready && !out_valid_reg |=> out_valid_reg && out_reg == $past(push_data))
        else $error("transfer into empty buffer not shown");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/panel_input_conditioner.sv
// top level of the panel input conditioner: tick processing and result buffering
//
// one input transfer is one 1 ms tick: encoder pins, two raw buttons (low when
// pressed), a hello flag from the panel and the operating mode. every tick gives
// exactly one result: routed encoder step, button events, beep request, current
// setpoint and power, save request, link state and report strobes.
// configuration is a plain write port (cfg_we, cfg_index, cfg_data); the user
// writes it only while no tick is in flight, which the block does not enforce;
// writing the initial setpoint or power also loads the current value.
// the result of a tick is valid the cycle after its transfer when the
// output register is empty or transfers in that same cycle.
// throughput: one tick per clock; the tick state update is a single pass of
// short logic (a few parallel timer subtract-and-compares) into registers.
// the result side has an output register plus a skid register, so one more tick
// is taken while a result waits; with both full, in_ready stays low and rises
// the cycle after the next output transfer.
// reset (rst_n low, asynchronous) restores all configuration defaults, clears
// the timers and button history to released, and empties the result buffer.
`timescale 1ns / 1ps
`default_nettype none

module panel_input_conditioner #(
    parameter int TIMER_BITS = 32
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic                               enc_a,
    input  wire logic                               enc_b,
    input  wire logic                               start_raw,
    input  wire logic                               encsw_raw,
    input  wire logic                               hello,
    input  wire logic [1:0]                         mode,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic signed [1:0]                       enc_to_panel,
    output logic                                    press_to_panel,
    output logic                                    hold_to_panel,
    output logic                                    start_stop,
    output logic [1:0]                              beep,
    output logic [5:0]                              setpoint,
    output logic [6:0]                              power_percent,
    output logic                                    save_request,
    output logic                                    panel_ok,
    output logic                                    link_came_up,
    output logic                                    status_due,
    output logic                                    send_journal,
    input  wire logic                               cfg_we,
    input  wire logic [pic_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [pic_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import pic_pkg::*;

    typedef logic [TIMER_BITS-1:0] tm_t;

    // configuration
    logic [15:0] hold_time_reg, link_timeout_reg, status_period_reg, journal_period_reg;
    logic [7:0]  button_period_reg;

    // tick state
    tm_t               time_now_reg, time_now_next;
    logic [1:0]        enc_last_reg, enc_last_next;
    logic signed [2:0] enc_partial_reg, enc_partial_next;
    logic [2:0]        start_samp_reg, start_samp_next;
    logic [2:0]        encsw_samp_reg, encsw_samp_next;
    logic              start_pressed_reg, start_pressed_next;
    logic              encsw_pressed_reg, encsw_pressed_next;
    logic              start_held_reg, start_held_next;
    tm_t               press_time_reg, press_time_next;
    tm_t               hello_time_reg, hello_time_next;
    logic              hello_seen_reg, hello_seen_next;
    logic              link_was_reg, link_was_next;
    tm_t               sample_mark_reg, sample_mark_next;
    tm_t               status_mark_reg, status_mark_next;
    tm_t               journal_mark_reg, journal_mark_next;
    logic [5:0]        cur_setpoint_reg, cur_setpoint_next;
    logic [6:0]        cur_power_reg, cur_power_next;

    logic              accept;
    res_t              res, out_res;
    logic              ok, sample_due, step_up, step_dn, came;
    logic signed [3:0] enc_sum;
    logic [6:0]        sp_up, sp_dn;
    logic [7:0]        pw_up, pw_dn;
    tm_t               journal_el;

    assign accept = in_valid && in_ready;

    always_comb
    begin
        res = '0;

        time_now_next   = time_now_reg + TIMER_BITS'(1);
        hello_time_next = hello ? time_now_next : hello_time_reg;
        hello_seen_next = hello_seen_reg || hello;
        ok = hello_seen_next
            && ((time_now_next - hello_time_next) < TIMER_BITS'(link_timeout_reg));

        // quadrature decode
        enc_last_next = {enc_a, enc_b};
        enc_sum = 4'(enc_partial_reg) + 4'(enc_dir({enc_last_reg, enc_a, enc_b}));
        step_up = 1'b0;
        step_dn = 1'b0;
        if (enc_sum >= 4'sd4)
        begin
            step_up          = 1'b1;
            enc_partial_next = 3'(enc_sum - 4'sd4);
        end
        else if (enc_sum <= -4'sd4)
        begin
            step_dn          = 1'b1;
            enc_partial_next = 3'(enc_sum + 4'sd4);
        end
        else
        begin
            enc_partial_next = 3'(enc_sum);
        end

        // buttons
        sample_due = (time_now_next - sample_mark_reg) >= TIMER_BITS'(button_period_reg);
        sample_mark_next   = sample_mark_reg;
        start_samp_next    = start_samp_reg;
        encsw_samp_next    = encsw_samp_reg;
        start_pressed_next = start_pressed_reg;
        encsw_pressed_next = encsw_pressed_reg;
        start_held_next    = start_held_reg;
        press_time_next    = press_time_reg;
        if (sample_due)
        begin
            sample_mark_next = time_now_next;
            start_samp_next  = {start_samp_reg[1:0], start_raw};
            encsw_samp_next  = {encsw_samp_reg[1:0], encsw_raw};

            if (start_samp_next == BTN_DOWN && !start_pressed_reg)
            begin
                start_pressed_next = 1'b1;
                press_time_next    = time_now_next;
                start_held_next    = 1'b0;
            end
            else if (start_samp_next == BTN_DOWN && !start_held_reg
                && (time_now_next - press_time_reg) >= TIMER_BITS'(hold_time_reg))
            begin
                start_held_next      = 1'b1;
                res.beep[BEEP_LONG]  = 1'b1;
                res.hold_to_panel    = ok;
            end
            else if (start_samp_next == BTN_RELEASE && start_pressed_reg)
            begin
                start_pressed_next = 1'b0;
                res.start_stop     = !start_held_reg;
            end

            if (encsw_samp_next == BTN_DOWN && !encsw_pressed_reg)
            begin
                encsw_pressed_next   = 1'b1;
                res.beep[BEEP_SHORT] = 1'b1;
                res.press_to_panel   = ok;
            end
            else if (encsw_samp_next == BTN_RELEASE && encsw_pressed_reg)
            begin
                encsw_pressed_next = 1'b0;
            end
        end

        // step routing, clamped adjustments
        sp_up = 7'(cur_setpoint_reg) + 7'd1;
        sp_dn = 7'(cur_setpoint_reg) - 7'd1;
        pw_up = 8'(cur_power_reg) + POWER_STEP;
        pw_dn = 8'(cur_power_reg) - POWER_STEP;
        cur_setpoint_next = cur_setpoint_reg;
        cur_power_next    = cur_power_reg;
        if (step_up || step_dn)
        begin
            if (ok)
            begin
                res.enc_to_panel = step_up ? 2'sd1 : -2'sd1;
            end
            else
            begin
                case (mode)
                    MODE_AUTO:
                    begin
                        res.save_request = 1'b1;
                        if (step_up)
                        begin
                            if (sp_up < SETPOINT_MIN)
                                cur_setpoint_next = 6'(SETPOINT_MIN);
                            else if (sp_up > SETPOINT_MAX)
                                cur_setpoint_next = 6'(SETPOINT_MAX);
                            else
                                cur_setpoint_next = sp_up[5:0];
                        end
                        else
                        begin
                            if (7'(cur_setpoint_reg) <= SETPOINT_MIN)
                                cur_setpoint_next = 6'(SETPOINT_MIN);
                            else if (sp_dn > SETPOINT_MAX)
                                cur_setpoint_next = 6'(SETPOINT_MAX);
                            else
                                cur_setpoint_next = sp_dn[5:0];
                        end
                    end
                    MODE_MANUAL:
                    begin
                        res.save_request = 1'b1;
                        if (step_up)
                        begin
                            if (pw_up < POWER_MIN)
                                cur_power_next = 7'(POWER_MIN);
                            else if (pw_up > POWER_MAX)
                                cur_power_next = 7'(POWER_MAX);
                            else
                                cur_power_next = pw_up[6:0];
                        end
                        else
                        begin
                            if (8'(cur_power_reg) < POWER_MIN + POWER_STEP)
                                cur_power_next = 7'(POWER_MIN);
                            else if (pw_dn > POWER_MAX)
                                cur_power_next = 7'(POWER_MAX);
                            else
                                cur_power_next = pw_dn[6:0];
                        end
                    end
                    default:
                    begin
                        res.save_request = 1'b0;
                    end
                endcase
            end
        end

        // link and report timing
        came          = ok && !link_was_reg;
        link_was_next = ok;
        status_mark_next = status_mark_reg;
        if ((time_now_next - status_mark_reg) >= TIMER_BITS'(status_period_reg))
        begin
            status_mark_next = time_now_next;
            res.status_due   = 1'b1;
        end
        journal_mark_next = came ? time_now_next : journal_mark_reg;
        journal_el = came ? '0 : time_now_next - journal_mark_reg;
        if (ok && journal_el >= TIMER_BITS'(journal_period_reg))
        begin
            journal_mark_next = time_now_next;
            res.send_journal  = 1'b1;
        end

        res.setpoint      = cur_setpoint_next;
        res.power_percent = cur_power_next;
        res.panel_ok      = ok;
        res.link_came_up  = came;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_time_reg        <= HOLD_TIME_RST;
            link_timeout_reg     <= LINK_TIMEOUT_RST;
            status_period_reg    <= STATUS_PERIOD_RST;
            journal_period_reg   <= JOURNAL_PERIOD_RST;
            button_period_reg    <= BUTTON_PERIOD_RST;
            time_now_reg      <= '0;
            enc_last_reg      <= ENC_REST;
            enc_partial_reg   <= '0;
            start_samp_reg    <= BTN_RELEASE;
            encsw_samp_reg    <= BTN_RELEASE;
            start_pressed_reg <= 1'b0;
            encsw_pressed_reg <= 1'b0;
            start_held_reg    <= 1'b0;
            press_time_reg    <= '0;
            hello_time_reg    <= '0;
            hello_seen_reg    <= 1'b0;
            link_was_reg      <= 1'b0;
            sample_mark_reg   <= '0;
            status_mark_reg   <= '0;
            journal_mark_reg  <= '0;
            cur_setpoint_reg  <= INITIAL_SETPOINT_RST;
            cur_power_reg     <= INITIAL_POWER_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HOLD_TIME:        hold_time_reg      <= cfg_data;
                REG_LINK_TIMEOUT:     link_timeout_reg   <= cfg_data;
                REG_STATUS_PERIOD:    status_period_reg  <= cfg_data;
                REG_JOURNAL_PERIOD:   journal_period_reg <= cfg_data;
                REG_BUTTON_PERIOD:    button_period_reg  <= cfg_data[7:0];
                REG_INITIAL_SETPOINT: cur_setpoint_reg   <= cfg_data[5:0];
                REG_INITIAL_POWER:    cur_power_reg      <= cfg_data[6:0];
                default:
                begin
                    hold_time_reg <= hold_time_reg;
                end
            endcase
        end
        else if (accept)
        begin
            time_now_reg      <= time_now_next;
            enc_last_reg      <= enc_last_next;
            enc_partial_reg   <= enc_partial_next;
            start_samp_reg    <= start_samp_next;
            encsw_samp_reg    <= encsw_samp_next;
            start_pressed_reg <= start_pressed_next;
            encsw_pressed_reg <= encsw_pressed_next;
            start_held_reg    <= start_held_next;
            press_time_reg    <= press_time_next;
            hello_time_reg    <= hello_time_next;
            hello_seen_reg    <= hello_seen_next;
            link_was_reg      <= link_was_next;
            sample_mark_reg   <= sample_mark_next;
            status_mark_reg   <= status_mark_next;
            journal_mark_reg  <= journal_mark_next;
            cur_setpoint_reg  <= cur_setpoint_next;
            cur_power_reg     <= cur_power_next;
        end
    end

    pic_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (res),
        .ready     (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_res)
    );

    assign enc_to_panel   = out_res.enc_to_panel;
    assign press_to_panel = out_res.press_to_panel;
    assign hold_to_panel  = out_res.hold_to_panel;
    assign start_stop     = out_res.start_stop;
    assign beep           = out_res.beep;
    assign setpoint       = out_res.setpoint;
    assign power_percent  = out_res.power_percent;
    assign save_request   = out_res.save_request;
    assign panel_ok       = out_res.panel_ok;
    assign link_came_up   = out_res.link_came_up;
    assign status_due     = out_res.status_due;
    assign send_journal   = out_res.send_journal;

`ifndef ASSERT_OFF
    a_partial_range: assert property (@(posedge clk) disable iff (!rst_n)
        enc_partial_reg != -3'sd4)
        else $error("encoder partial count out of range");

    a_link_needs_hello: assert property (@(posedge clk) disable iff (!rst_n)
        link_was_reg |-> hello_seen_reg)
        else $error("link up without any hello");

    a_came_up_once: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !cfg_we && res.link_came_up |=> link_was_reg)
        else $error("link rise not recorded");
`endif

endmodule

`default_nettype wire
